@@ rtl/bts_pkg.sv @@
// Shared types, constants and helpers for the bilinear texture sampler.
// No dependencies; imported by bts_store, bilinear_texture_sampler and the testbench.
package bts_pkg;

  typedef logic [23:0] texel_t;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [8:0]  MAX_DIM = 9'd256;
  localparam logic [8:0]  DIM_RST = 9'd256;

  // clamp a signed Q1.16 coordinate into 0..1.0
  function automatic logic [16:0] clamp_coord(input logic [17:0] raw);
    logic [16:0] res;
    if (raw[17]) res = '0;
    else if (raw[16:0] > ONE_Q16) res = ONE_Q16;
    else res = raw[16:0];
    return res;
  endfunction

  // width or height as used: 0 acts as 1, above 256 acts as 256
  function automatic logic [8:0] dim_eff(input logic [8:0] d);
    logic [8:0] res;
    if (d == 9'd0) res = 9'd1;
    else if (d > MAX_DIM) res = MAX_DIM;
    else res = d;
    return res;
  endfunction

endpackage

@@ rtl/bts_store.sv @@
// Texel store: two copies of the texel memory, each with two read ports.
// Depends on bts_pkg (texel_t).
module bts_store import bts_pkg::*; #(
  parameter int TEX_WORDS = 65536,
  parameter int AW        = 16
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] raddr_i [4],
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  texel_t        wdata_i,
  output texel_t        rdata_o [4]
);

  texel_t mem_a [TEX_WORDS];
  texel_t mem_b [TEX_WORDS];

  // copy A serves corners 0 and 1, copy B corners 2 and 3
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_a[waddr_i] <= wdata_i;
      mem_b[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_o[0] <= mem_a[raddr_i[0]];
      rdata_o[1] <= mem_a[raddr_i[1]];
      rdata_o[2] <= mem_b[raddr_i[2]];
      rdata_o[3] <= mem_b[raddr_i[3]];
    end
  end

endmodule

@@ rtl/bilinear_texture_sampler.sv @@
// Bilinear texture sampler top level: pipeline, configuration registers.
// Depends on bts_pkg and bts_store.
//
// Usage:
//   Input beats arrive on s_axis; tuser selects a load (write one texel at
//   texel_addr) or a sample (filter at coord_u, coord_v). Each sample gives
//   one output beat on m_axis with the blended red, green and blue in units
//   of 1/255 with 8 fraction bits; loads give no output beat.
//   Width and height are set over the APB port at byte addresses 0 and 4;
//   the user must write them only while the pipeline is empty (not enforced).
// Timing:
//   One beat per cycle, sustained unless the output stalls. A sample passes
//   through clamp and scale, row multiply, index add, three steps of store
//   wrap, the store read, and three blend steps on its way to m_axis. The
//   store holds two copies of the texels so the four corners are read
//   together; a load lands in the same stage where samples read, so order
//   is kept without forwarding.
// Stall and reset:
//   When m_axis_tready_i is low with a beat waiting, the whole pipeline
//   holds, and s_axis_tready_o drops. Reset empties the pipeline and sets
//   width and height to 256; the texel store is not cleared.
module bilinear_texture_sampler import bts_pkg::*; #(
  parameter int TEX_WORDS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] texel_addr, [23:16] texel_red, [31:24] texel_green,
  // [39:32] texel_blue, [57:40] coord_u, [75:58] coord_v, [79:76] zero
  input  logic [79:0] s_axis_tdata_i,
  // [0] kind
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] red_out, [31:16] green_out, [47:32] blue_out
  output logic [47:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int          AW    = $clog2(TEX_WORDS);
  localparam logic [31:0] NW    = 32'(TEX_WORDS);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TEX_WORDS);

  // ---------------- configuration ----------------
  logic [8:0] tex_width_q, tex_height_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= DIM_RST;
      tex_height_q <= DIM_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_WIDTH:  tex_width_q  <= pwdata[8:0];
        REG_HEIGHT: tex_height_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_WIDTH:  prdata = {23'd0, tex_width_q};
      REG_HEIGHT: prdata = {23'd0, tex_height_q};
      default:    prdata = '0;
    endcase
  end

  logic [8:0] w_eff, h_eff;
  logic [7:0] w_m1, h_m1;
  assign w_eff = dim_eff(tex_width_q);
  assign h_eff = dim_eff(tex_height_q);
  assign w_m1  = 8'(w_eff - 9'd1);
  assign h_m1  = 8'(h_eff - 9'd1);

  // ---------------- pipeline control ----------------
  logic adv;
  logic m_valid_q;
  assign adv             = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = m_valid_q;

  // valid and kind per stage 1..10
  logic [10:1] vld_q;
  logic [10:1] knd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[9:1], s_axis_tvalid_i};
      m_valid_q <= vld_q[10] && (knd_q[10] == KIND_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) knd_q <= {knd_q[9:1], s_axis_tuser_i};
  end

  // load payload travels with the beat up to the store stage
  logic [15:0] ld_addr_q [1:7];
  texel_t      ld_data_q [1:7];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ld_addr_q[1] <= s_axis_tdata_i[15:0];
      ld_data_q[1] <= {s_axis_tdata_i[23:16], s_axis_tdata_i[31:24],
                       s_axis_tdata_i[39:32]};
      for (int i = 2; i <= 7; i++) begin
        ld_addr_q[i] <= ld_addr_q[i-1];
        ld_data_q[i] <= ld_data_q[i-1];
      end
    end
  end

  // ---------------- stage 1: capture coordinates ----------------
  logic [17:0] u1_q, v1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      u1_q <= s_axis_tdata_i[57:40];
      v1_q <= s_axis_tdata_i[75:58];
    end
  end

  // ---------------- stage 2: clamp and scale ----------------
  logic [23:0] su2_q, sv2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      su2_q <= 24'(clamp_coord(u1_q) * w_m1);
      sv2_q <= 24'(clamp_coord(v1_q) * h_m1);
    end
  end

  // ---------------- stage 3: corners and row offsets ----------------
  logic [7:0]  xmin3_q, xmax3_q;
  logic [15:0] rmin3_q, rmax3_q;
  logic [15:0] s_q [3:8];
  logic [15:0] t_q [3:8];
  logic [7:0]  ymax2;
  assign ymax2 = sv2_q[23:16] + {7'd0, |sv2_q[15:0]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xmin3_q <= su2_q[23:16];
      xmax3_q <= su2_q[23:16] + {7'd0, |su2_q[15:0]};
      rmin3_q <= 16'(sv2_q[23:16] * w_eff);
      rmax3_q <= 16'(ymax2 * w_eff);
      s_q[3]  <= su2_q[15:0];
      t_q[3]  <= sv2_q[15:0];
      for (int i = 4; i <= 8; i++) begin
        s_q[i] <= s_q[i-1];
        t_q[i] <= t_q[i-1];
      end
    end
  end

  // ---------------- stage 4: linear indices ----------------
  logic [15:0] idx4_q [4];
  logic [15:0] idx5_q [4];
  logic [15:0] idx6_q [4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx4_q[0] <= rmin3_q + {8'd0, xmin3_q};
      idx4_q[1] <= rmin3_q + {8'd0, xmax3_q};
      idx4_q[2] <= rmax3_q + {8'd0, xmax3_q};
      idx4_q[3] <= rmax3_q + {8'd0, xmin3_q};
    end
  end

  // ---------------- stages 5..7: wrap modulo store depth ----------------
  logic [15:0]   q5_q [4];
  logic [15:0]   p6_q [4];
  logic [AW-1:0] raddr7_q [4];
  logic [47:0]   qprod [4];
  logic [47:0]   pprod [4];
  logic [15:0]   rem   [4];
  logic [31:0]   rfix  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qprod[i] = {32'd0, idx4_q[i]} * {16'd0, RECIP};
      pprod[i] = {32'd0, q5_q[i]} * {16'd0, NW};
      rem[i]   = idx6_q[i] - p6_q[i];
      rfix[i]  = (32'(rem[i]) >= NW) ? 32'(rem[i]) - NW : 32'(rem[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        q5_q[i]     <= qprod[i][47:32];
        idx5_q[i]   <= idx4_q[i];
        p6_q[i]     <= pprod[i][15:0];
        idx6_q[i]   <= idx5_q[i];
        raddr7_q[i] <= rfix[i][AW-1:0];
      end
    end
  end

  // ---------------- stage 8: store access ----------------
  logic [31:0]   ld_ext;
  logic [AW-1:0] waddr;
  logic          we;
  texel_t        tex8 [4];

  assign ld_ext = 32'(ld_addr_q[7]);
  assign waddr  = ld_ext[AW-1:0];
  assign we     = adv && vld_q[7] && (knd_q[7] == KIND_LOAD) && (ld_ext < NW);

  bts_store #(
    .TEX_WORDS(TEX_WORDS),
    .AW       (AW)
  ) u_store (
    .clk_i  (clk_i),
    .rd_en_i(adv),
    .raddr_i(raddr7_q),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(ld_data_q[7]),
    .rdata_o(tex8)
  );

  // ---------------- stage 9: horizontal blend ----------------
  logic [23:0] top9_q [3];
  logic [23:0] bot9_q [3];
  logic [15:0] t9_q;
  logic [16:0] sn8;
  logic [24:0] top8 [3];
  logic [24:0] bot8 [3];

  assign sn8 = ONE_Q16 - {1'b0, s_q[8]};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      top8[c] = 25'(sn8 * tex8[0][23-8*c -: 8]) + 25'(s_q[8] * tex8[1][23-8*c -: 8]);
      bot8[c] = 25'(sn8 * tex8[3][23-8*c -: 8]) + 25'(s_q[8] * tex8[2][23-8*c -: 8]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        top9_q[c] <= top8[c][23:0];
        bot9_q[c] <= bot8[c][23:0];
      end
      t9_q <= t_q[8];
    end
  end

  // ---------------- stage 10: vertical weights ----------------
  logic [39:0] pt10_q [3];
  logic [39:0] pb10_q [3];
  logic [16:0] tn9;
  assign tn9 = ONE_Q16 - {1'b0, t9_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        pt10_q[c] <= 40'(tn9 * top9_q[c]);
        pb10_q[c] <= 40'(t9_q * bot9_q[c]);
      end
    end
  end

  // ---------------- stage 11: sum, truncate, output register ----------------
  logic [39:0] sum10 [3];
  logic [47:0] out_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum10[c] = pt10_q[c] + pb10_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {sum10[2][39:24], sum10[1][39:24], sum10[0][39:24]};
    end
  end

  assign m_axis_tdata_o = out_q;

endmodule

@@ sim/tb_bilinear_texture_sampler.sv @@
// Self-checking testbench for bilinear_texture_sampler: texel loads, filtered samples, APB setup.
// Depends on bts_pkg and the sampler RTL; everything else is generated here.
`timescale 1ns / 100ps

module tb_bilinear_texture_sampler;
  import bts_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // [15:0] texel_addr, [23:16] texel_red, [31:24] texel_green,
  // [39:32] texel_blue, [57:40] coord_u, [75:58] coord_v, [79:76] zero
  logic [79:0] s_axis_tdata_i;
  // [0] kind
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // [15:0] red_out, [31:16] green_out, [47:32] blue_out
  logic [47:0] m_axis_tdata_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  bilinear_texture_sampler dut (.*);

  // Byte addresses of the two dimension registers, and one more that wraps to 0 (width)
  localparam logic [2:0] ADDR_WIDTH  = 3'(4 * REG_WIDTH);
  localparam logic [2:0] ADDR_HEIGHT = 3'(4 * REG_HEIGHT);
  localparam logic [2:0] ADDR_UNUSED = 3'd0 + 3'd4 + 3'd4;
  localparam int         DRAIN_CYCLES = 20;

  // Predictor state: its own copy of the texel store and the dimension registers
  texel_t      texels [int unsigned];
  logic [8:0]  width_reg, height_reg;
  logic [47:0] rgb_expected [$];
  int          err_count;
  int          sent_count;
  logic        no_idle;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(4ns * 2_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, or a long hold-off counted here when requested
  initial begin
    int hold_cnt;
    int stall;
    hold_cnt = 0;
    stall = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Result checker: compare each output beat with the oldest expectation
  always @(posedge clk_i) begin
    logic [47:0] want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (rgb_expected.size() == 0) begin
        $error("unexpected output beat %h", m_axis_tdata_o);
        err_count++;
      end else begin
        want = rgb_expected.pop_front();
        if (want[15:0] !== m_axis_tdata_o[15:0]) begin
          $error("red_out: expected %0d, got %0d", want[15:0], m_axis_tdata_o[15:0]);
          err_count++;
        end
        if (want[31:16] !== m_axis_tdata_o[31:16]) begin
          $error("green_out: expected %0d, got %0d", want[31:16], m_axis_tdata_o[31:16]);
          err_count++;
        end
        if (want[47:32] !== m_axis_tdata_o[47:32]) begin
          $error("blue_out: expected %0d, got %0d", want[47:32], m_axis_tdata_o[47:32]);
          err_count++;
        end
      end
    end
  end

  function automatic int unsigned eff_dim(logic [8:0] d);
    if (d == 9'd0) return 1;
    if (d > 9'd256) return 256;
    return d;
  endfunction

  function automatic int unsigned clamp_q16(logic signed [17:0] c);
    if (c < 0) return 0;
    if (c > 18'sd65536) return 65536;
    return c;
  endfunction

  // Four corner indices of a sample, in order floor/floor, ceil/floor, ceil/ceil, floor/ceil
  function automatic void corners(input logic signed [17:0] u, input logic signed [17:0] v,
                                  output int unsigned idx [4], output int unsigned s,
                                  output int unsigned t);
    int unsigned w, h, su, sv, x0, y0, x1, y1;
    w  = eff_dim(width_reg);
    h  = eff_dim(height_reg);
    su = clamp_q16(u) * (w - 1);
    sv = clamp_q16(v) * (h - 1);
    x0 = su >> 16;
    y0 = sv >> 16;
    s  = su & 16'hFFFF;
    t  = sv & 16'hFFFF;
    x1 = x0 + (s != 0);
    y1 = y0 + (t != 0);
    idx[0] = (y0 * w + x0) % 65536;
    idx[1] = (y0 * w + x1) % 65536;
    idx[2] = (y1 * w + x1) % 65536;
    idx[3] = (y1 * w + x0) % 65536;
  endfunction

  // Exact bilinear blend of the four corners, truncated to 8 fraction bits
  function automatic logic [47:0] blend_rgb(logic signed [17:0] u, logic signed [17:0] v);
    int unsigned     idx [4];
    int unsigned     s, t;
    longint unsigned wt [4];
    longint unsigned acc;
    logic [47:0]     res;
    texel_t          tx;
    corners(u, v, idx, s, t);
    wt[0] = longint'(65536 - s) * (65536 - t);
    wt[1] = longint'(s) * (65536 - t);
    wt[2] = longint'(s) * t;
    wt[3] = longint'(65536 - s) * t;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        tx  = texels[idx[k]];
        acc += wt[k] * ((tx >> (16 - 8 * ch)) & 8'hFF);
      end
      res[16*ch +: 16] = 16'(acc >> 24);
    end
    return res;
  endfunction

  // Send one beat and predict its effect; returns after acceptance and any gap
  task automatic send_beat(input kind_e kind, input logic [15:0] addr, input texel_t rgb,
                           input logic signed [17:0] u, input logic signed [17:0] v);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {4'b0, v, u, rgb[7:0], rgb[15:8], rgb[23:16], addr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_count++;
    if (kind == KIND_LOAD) texels[addr] = rgb;
    else rgb_expected.push_back(blend_rgb(u, v));
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_texel(input logic [15:0] addr, input texel_t rgb);
    send_beat(KIND_LOAD, addr, rgb, '0, '0);
  endtask

  // Load any corner not yet written, then send the sample, so it never reads an empty entry
  task automatic sample_at(input logic signed [17:0] u, input logic signed [17:0] v);
    int unsigned idx [4];
    int unsigned s, t;
    corners(u, v, idx, s, t);
    foreach (idx[k])
      if (!texels.exists(idx[k])) load_texel(16'(idx[k]), 24'($urandom));
    send_beat(KIND_SAMPLE, '0, '0, u, v);
  endtask

  function automatic logic signed [17:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 18'($urandom);
      1: return $urandom_range(0, 1) ? 18'sd65536 : 18'sd0;
      2: return 18'sd65536 + 18'($urandom_range(1, 65535));
      3: return -18'sd1 - 18'($urandom_range(0, 131071));
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  // Hold until every expected result is out and the pipeline has emptied
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    wait (rgb_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_WIDTH) width_reg = data[8:0];
    else if (addr == ADDR_HEIGHT) height_reg = data[8:0];
    @(posedge clk_i);
  endtask

  task automatic apb_check(input logic [2:0] addr, input logic [8:0] want);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[8:0] !== want) begin
      $error("prdata: expected %0d, got %0d", want, prdata[8:0]);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_dims(input logic [8:0] w, input logic [8:0] h);
    wait_idle();
    apb_write(ADDR_WIDTH, {23'($urandom), w});
    apb_write(ADDR_HEIGHT, {23'($urandom), h});
    apb_check(ADDR_WIDTH, w);
    apb_check(ADDR_HEIGHT, h);
  endtask

  // Extremes at reset dimensions: store ends, all-zero and all-one texels, edge coords
  task automatic test_directed();
    load_texel(16'h0000, 24'h000000);
    load_texel(16'hFFFF, 24'hFFFFFF);
    load_texel(16'h0001, 24'hFF00FF);
    load_texel(16'h0100, 24'h00FF00);
    load_texel(16'h0101, 24'h123456);
    sample_at(18'sd0, 18'sd0);
    sample_at(18'sd65536, 18'sd65536);
    sample_at(-18'sd131072, 18'sd131071);
    sample_at(18'sd131071, -18'sd1);
    sample_at(18'sd65537, 18'sd0);
    sample_at(18'sd128, 18'sd128);
    sample_at(18'sd255, 18'sd256);
    sample_at(18'sd65535, 18'sd65535);
    sample_at(18'sd32768, 18'sd32768);
  endtask

  // Register map: both dimensions, their out-of-range values, and a write whose address wraps to width
  task automatic test_registers();
    set_dims(9'd0, 9'd511);
    sample_at(18'sd40000, 18'sd65536);
    sample_at(18'sd65536, 18'sd12345);
    wait_idle();
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    apb_check(ADDR_WIDTH, width_reg);
    apb_check(ADDR_HEIGHT, height_reg);
    sample_at(18'sd777, 18'sd40000);
  endtask

  // Random mix of loads and samples under one dimension setting, counted in beats
  task automatic run_random(input int n_items);
    int stop_at;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 99) < 25) load_texel(16'($urandom), 24'($urandom));
      else sample_at(rand_coord(), rand_coord());
    end
  endtask

  task automatic test_random_sweep();
    logic [8:0] dims [10][2];
    dims = '{'{9'd1, 9'd1}, '{9'd256, 9'd256}, '{9'd256, 9'd1}, '{9'd1, 9'd256},
             '{9'd511, 9'd0}, '{9'd2, 9'd2}, '{9'd0, 9'd0}, '{9'd3, 9'd7},
             '{9'd100, 9'd200}, '{9'd255, 9'd17}};
    foreach (dims[k]) begin
      set_dims(dims[k][0], dims[k][1]);
      no_idle = (k % 3 == 1);
      run_random(110);
    end
    no_idle = 1'b0;
    repeat (5) begin
      set_dims(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)));
      run_random(110);
    end
  endtask

  // Long receiver hold-off while the sender keeps offering, then a full drain and a further random run
  task automatic test_backpressure();
    set_dims(9'd16, 9'd16);
    no_idle = 1'b1;
    hold_req = 1'b1;
    run_random(80);
    no_idle = 1'b0;
    wait_idle();
    run_random(20);
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = KIND_LOAD;
    s_axis_tdata_i  = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    width_reg       = DIM_RST;
    height_reg      = DIM_RST;
    err_count       = 0;
    sent_count      = 0;
    no_idle         = 1'b0;
    hold_req        = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_registers();
    test_random_sweep();
    test_backpressure();
    wait_idle();

    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bts_pkg.sv
rtl/bts_store.sv
rtl/bilinear_texture_sampler.sv
sim/tb_bilinear_texture_sampler.sv
